/* design/button_edge_and_typematic_repeat_macros.svh */
// Assertion macros used by the checker file of the button repeat block.
`ifndef BUTTON_EDGE_AND_TYPEMATIC_REPEAT_MACROS_SVH
`define BUTTON_EDGE_AND_TYPEMATIC_REPEAT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define BTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bte_pkg.sv */
// Shared types and constants of the button edge and repeat block.
package bte_pkg;

  localparam int unsigned NUM_BUTTONS = 15;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned MS_CFG_W = 16;
  localparam int unsigned BTN_W = 4;

  localparam logic [MS_CFG_W-1:0] DELAY_RESET = 16'd300;
  localparam logic [MS_CFG_W-1:0] INTERVAL_RESET = 16'd50;

  // Configuration register indexes.
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    MODE_DOWN  = 2'd0,
    MODE_UP    = 2'd1,
    MODE_POLL  = 2'd2,
    MODE_FRAME = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [BTN_W-1:0]   button_index;
    logic [STAMP_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [MS_CFG_W-1:0] repeat_delay_ms;
    logic [MS_CFG_W-1:0] repeat_interval_ms;
  } cfg_t;

  // is_down sits in the lowest bit.
  typedef struct packed {
    logic repeat_fire;
    logic just_pressed;
    logic is_down;
  } res_t;

endpackage

/* design/button_edge_and_typematic_repeat.sv */
// Top level of the button edge detector with typematic repeat.
//
// Requests enter on the s_ stream: s_tuser carries the mode (key down, key up,
// poll, frame end) and s_tdata the button index and the millisecond stamp.
// Only a poll of a button in range produces a result on the m_ stream:
// held, freshly pressed since the last frame end, and repeat due.
// Repeat fires on a fresh press, then once the button has been held for
// repeat_delay_ms, then each time repeat_interval_ms has passed.
// The two timing registers are written through cfg_we, cfg_index, cfg_data.
//
// The input register captures each request; when the core takes it, the
// button state is updated and the result register loaded. The block takes
// one request per cycle while the result register is not stalled; the rate
// is set by the read-modify-write of the per-button state.
// When the receiver holds m_tready low with a result waiting, the input
// register fills and s_tready drops until the result is taken.
// Reset clears all button state, empties both registers and loads the timing
// registers with 300 ms and 50 ms.
module button_edge_and_typematic_repeat import bte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [3:0] button_index, [35:4] now_ms, rest zero
  input  logic [1:0]  s_tuser,  // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [0] is_down, [1] just_pressed, [2] repeat_fire
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  item_t item_in;
  item_t item_q;
  logic  item_valid;
  logic  go;
  cfg_t  cfg;
  logic  res_valid;
  res_t  res;
  res_t  res_q;

  assign item_in.mode = mode_t'(s_tuser);
  assign item_in.button_index = s_tdata[3:0];
  assign item_in.now_ms = s_tdata[35:4];

  // A request is processed once the result register is free or draining.
  assign go = item_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_delay_ms <= DELAY_RESET;
      cfg.repeat_interval_ms <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY:    cfg.repeat_delay_ms <= cfg_data;
        REG_INTERVAL: cfg.repeat_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bte_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .item     (item_in),
    .take     (go),
    .valid    (item_valid),
    .item_q   (item_q)
  );

  bte_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .go        (go),
    .item      (item_q),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {5'b0, res_q};

endmodule

/* design/bte_in_reg.sv */
// Input register that holds one request until the core takes it.
module bte_in_reg import bte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  item_t item,
  input  logic  take,
  output logic  valid,
  output item_t item_q
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q <= item;
    end
  end

endmodule

/* design/bte_core.sv */
// Per-button state and the single-pass update and repeat decision.
module bte_core import bte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  go,
  input  item_t item,
  output logic  res_valid,
  output res_t  res
);

  logic [NUM_BUTTONS-1:0] down_bits;
  logic [NUM_BUTTONS-1:0] previous_bits;
  logic [NUM_BUTTONS-1:0] repeat_started;
  logic [STAMP_W-1:0]     press_stamp  [NUM_BUTTONS];
  logic [STAMP_W-1:0]     repeat_stamp [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0] hit;
  logic                   in_range;
  logic                   sel_down;
  logic                   sel_prev;
  logic                   sel_started;
  logic [STAMP_W-1:0]     sel_press;
  logic [STAMP_W-1:0]     sel_repeat;
  logic [STAMP_W-1:0]     hold_span;
  logic [STAMP_W-1:0]     since_repeat;
  logic                   fresh;
  logic                   auto_fire;

  always_comb begin
    hit = '0;
    sel_press = '0;
    sel_repeat = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hit[i] = (32'(item.button_index) == 32'(i));
      sel_press = sel_press | (press_stamp[i] & {STAMP_W{hit[i]}});
      sel_repeat = sel_repeat | (repeat_stamp[i] & {STAMP_W{hit[i]}});
    end
  end

  assign in_range = 32'(item.button_index) < 32'(NUM_BUTTONS);
  assign sel_down = |(down_bits & hit);
  assign sel_prev = |(previous_bits & hit);
  assign sel_started = |(repeat_started & hit);

  // Differences wrap modulo 2^32, as the timestamps do.
  assign hold_span = item.now_ms - sel_press;
  assign since_repeat = item.now_ms - sel_repeat;

  assign fresh = sel_down && !sel_prev;
  assign auto_fire = sel_down && !fresh
                     && (hold_span >= {{(STAMP_W-MS_CFG_W){1'b0}}, cfg.repeat_delay_ms})
                     && (!sel_started
                         || (since_repeat >= {{(STAMP_W-MS_CFG_W){1'b0}},
                                              cfg.repeat_interval_ms}));

  assign res_valid = go && (item.mode == MODE_POLL) && in_range;
  assign res.is_down = sel_down;
  assign res.just_pressed = fresh;
  assign res.repeat_fire = fresh || auto_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_bits <= '0;
      previous_bits <= '0;
      repeat_started <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_stamp[i] <= '0;
        repeat_stamp[i] <= '0;
      end
    end else if (go) begin
      case (item.mode)
        MODE_FRAME: begin
          previous_bits <= down_bits;
        end
        MODE_DOWN: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (hit[i]) begin
              previous_bits[i] <= down_bits[i];
              if (!down_bits[i]) begin
                down_bits[i] <= 1'b1;
                press_stamp[i] <= item.now_ms;
                repeat_started[i] <= 1'b0;
              end
            end
          end
        end
        MODE_UP: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (hit[i]) begin
              previous_bits[i] <= down_bits[i];
              down_bits[i] <= 1'b0;
              press_stamp[i] <= '0;
              repeat_stamp[i] <= '0;
              repeat_started[i] <= 1'b0;
            end
          end
        end
        MODE_POLL: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (hit[i] && auto_fire) begin
              repeat_started[i] <= 1'b1;
              repeat_stamp[i] <= item.now_ms;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/bte_checker.sv */
// Port-level checks of the button repeat block, bound to its top level.
`include "button_edge_and_typematic_repeat_macros.svh"

module bte_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  `BTE_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result shown right after reset")
  `BTE_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `BTE_ASSERT(a_fresh_held, m_tvalid && m_tdata[1] |-> m_tdata[0], "fresh press on a released button")
  `BTE_ASSERT(a_fresh_fires, m_tvalid && m_tdata[1] |-> m_tdata[2], "fresh press without repeat fire")
  `BTE_ASSERT(a_fire_held, m_tvalid && m_tdata[2] |-> m_tdata[0], "repeat fire on a released button")

endmodule

bind button_edge_and_typematic_repeat bte_checker u_bte_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the button edge detector with typematic repeat.
module testbench;
  import bte_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // [3:0] button_index, [35:4] now_ms, rest zero
  logic [1:0]  s_tuser = MODE_FRAME;  // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // [0] is_down, [1] just_pressed, [2] repeat_fire
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_DELAY;
  logic [15:0] cfg_data = '0;

  button_edge_and_typematic_repeat dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Per-button state of the predictor.
  logic                key_held      [NUM_BUTTONS];
  logic                held_at_frame [NUM_BUTTONS];
  logic [STAMP_W-1:0]  press_ms      [NUM_BUTTONS];
  logic [STAMP_W-1:0]  repeat_time   [NUM_BUTTONS];
  logic                repeat_armed  [NUM_BUTTONS];
  logic [MS_CFG_W-1:0] delay_ms_cfg;
  logic [MS_CFG_W-1:0] interval_ms_cfg;

  res_t        pending_poll_results[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;
  logic [31:0] clock_ms = '0;

  function automatic void clear_buttons();
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      key_held[i] = 1'b0;
      held_at_frame[i] = 1'b0;
      press_ms[i] = '0;
      repeat_time[i] = '0;
      repeat_armed[i] = 1'b0;
    end
    delay_ms_cfg = DELAY_RESET;
    interval_ms_cfg = INTERVAL_RESET;
  endfunction

  // Applies one accepted request to the predicted button state and queues the
  // poll result that it produces, if any.
  function automatic void apply_button_request(mode_t mode, logic [BTN_W-1:0] btn,
                                               logic [STAMP_W-1:0] now);
    res_t               res;
    logic [STAMP_W-1:0] held_for;
    logic [STAMP_W-1:0] since_repeat;
    if (mode == MODE_FRAME) begin
      for (int i = 0; i < NUM_BUTTONS; i++)
        held_at_frame[i] = key_held[i];
      return;
    end
    if (btn >= NUM_BUTTONS)
      return;
    case (mode)
      MODE_DOWN: begin
        held_at_frame[btn] = key_held[btn];
        if (!key_held[btn]) begin
          key_held[btn] = 1'b1;
          press_ms[btn] = now;
          repeat_armed[btn] = 1'b0;
        end
      end
      MODE_UP: begin
        held_at_frame[btn] = key_held[btn];
        key_held[btn] = 1'b0;
        press_ms[btn] = '0;
        repeat_time[btn] = '0;
        repeat_armed[btn] = 1'b0;
      end
      default: begin
        res.is_down = key_held[btn];
        res.just_pressed = key_held[btn] && !held_at_frame[btn];
        res.repeat_fire = 1'b0;
        held_for = now - press_ms[btn];
        since_repeat = now - repeat_time[btn];
        if (res.just_pressed) begin
          res.repeat_fire = 1'b1;
        end else if (res.is_down && held_for >= {16'b0, delay_ms_cfg}) begin
          if (!repeat_armed[btn] || since_repeat >= {16'b0, interval_ms_cfg}) begin
            repeat_armed[btn] = 1'b1;
            repeat_time[btn] = now;
            res.repeat_fire = 1'b1;
          end
        end
        pending_poll_results.push_back(res);
      end
    endcase
  endfunction

  // Offers one request and returns at the edge that accepts it. Valid stays
  // high afterwards so that back-to-back requests need no second assignment.
  task automatic send_request(mode_t mode, logic [BTN_W-1:0] btn, logic [STAMP_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, now, btn};
    do @(posedge clk); while (!s_tready);
    apply_button_request(mode, btn, now);
  endtask

  // Waits until every poll result has arrived and the pipeline has emptied.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_poll_results.size() != 0 || hold_off_cycles > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_timing(logic [MS_CFG_W-1:0] delay, logic [MS_CFG_W-1:0] interval);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_index <= REG_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    cfg_index <= REG_INTERVAL;
    cfg_data <= interval;
    @(posedge clk);
    cfg_we <= 1'b0;
    delay_ms_cfg = delay;
    interval_ms_cfg = interval;
  endtask

  // Random traffic that concentrates on a few buttons and advances time in
  // steps comparable to the timing registers, so held buttons reach the delay
  // and the repeat interval.
  task automatic run_random_traffic(int count);
    int               pick;
    int               step_max;
    mode_t            mode;
    logic [BTN_W-1:0] btn;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      mode = MODE_POLL;
      else if (pick < 70) mode = MODE_DOWN;
      else if (pick < 78) mode = MODE_UP;
      else                mode = MODE_FRAME;
      if ($urandom_range(0, 3) == 0) btn = 4'($urandom_range(0, 15));
      else                           btn = 4'($urandom_range(0, 3));
      step_max = (int'(delay_ms_cfg) + int'(interval_ms_cfg)) / 4 + 8;
      if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
      else                           clock_ms = clock_ms + $urandom_range(0, step_max);
      send_request(mode, btn, clock_ms);
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(MODE_POLL, 4'd0, 32'd0);
    send_request(MODE_DOWN, 4'd0, 32'd1000);
    send_request(MODE_POLL, 4'd0, 32'd1000);
    // Still a fresh press until the next frame end.
    send_request(MODE_POLL, 4'd0, 32'd1100);
    send_request(MODE_FRAME, 4'd15, 32'd1100);
    send_request(MODE_POLL, 4'd0, 32'd1299);
    send_request(MODE_POLL, 4'd0, 32'd1300);
    send_request(MODE_POLL, 4'd0, 32'd1349);
    send_request(MODE_POLL, 4'd0, 32'd1350);
    // A second key down on a held button keeps the press time.
    send_request(MODE_DOWN, 4'd0, 32'd1400);
    send_request(MODE_POLL, 4'd0, 32'd1400);
    send_request(MODE_UP, 4'd0, 32'd1500);
    send_request(MODE_POLL, 4'd0, 32'd1500);
    // Index out of range is ignored for every mode but frame end.
    send_request(MODE_DOWN, 4'd15, 32'd1500);
    send_request(MODE_POLL, 4'd15, 32'd1500);
    send_request(MODE_UP, 4'd15, 32'd1500);
    // Held time across the 32-bit wrap of the millisecond counter.
    send_request(MODE_DOWN, 4'd14, 32'hFFFF_FF00);
    send_request(MODE_FRAME, 4'd0, 32'hFFFF_FF00);
    send_request(MODE_POLL, 4'd14, 32'h0000_0040);
    send_request(MODE_POLL, 4'd14, 32'h0000_0071);
    send_request(MODE_DOWN, 4'd8, 32'hFFFF_FFFF);
    send_request(MODE_POLL, 4'd8, 32'hFFFF_FFFF);
    send_request(MODE_UP, 4'd14, 32'h0000_0080);
    send_request(MODE_POLL, 4'd14, 32'h0000_0080);
  endtask

  task automatic test_reset_timing();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_traffic(150);
  endtask

  task automatic test_zero_timing();
    program_timing(16'd0, 16'd0);
    send_idle_pct = 55;
    recv_stall_pct = 0;
    run_random_traffic(150);
  endtask

  task automatic test_max_timing();
    program_timing(16'hFFFF, 16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 55;
    run_random_traffic(150);
  endtask

  task automatic test_random_timing();
    for (int k = 0; k < 3; k++) begin
      program_timing(16'($urandom_range(0, 600)), 16'($urandom_range(0, 120)));
      send_idle_pct = 9;
      recv_stall_pct = 9;
      run_random_traffic(100);
    end
    program_timing(16'd1, 16'hFFFF);
    send_idle_pct = 55;
    recv_stall_pct = 55;
    run_random_traffic(100);
  endtask

  // The receiver holds off while polls keep coming, so the result and input
  // registers fill and the block must stall its input.
  task automatic test_output_backpressure();
    program_timing(16'd20, 16'd5);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(MODE_DOWN, 4'd3, clock_ms);
    hold_off_cycles = 200;
    for (int n = 0; n < 40; n++) begin
      clock_ms = clock_ms + $urandom_range(0, 8);
      send_request(MODE_POLL, 4'd3, clock_ms);
    end
  endtask

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_poll_results
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[2:0]);
      if (pending_poll_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected poll result: expected none, actual down=%b pressed=%b repeat=%b",
                 $time, got.is_down, got.just_pressed, got.repeat_fire);
      end else begin
        want = pending_poll_results.pop_front();
        if (got.is_down !== want.is_down || got.just_pressed !== want.just_pressed ||
            got.repeat_fire !== want.repeat_fire) begin
          mismatch_count++;
          $display("%0t: poll result mismatch: expected down=%b pressed=%b repeat=%b, actual down=%b pressed=%b repeat=%b",
                   $time, want.is_down, want.just_pressed, want.repeat_fire,
                   got.is_down, got.just_pressed, got.repeat_fire);
        end
      end
    end
  end

  initial begin
    clear_buttons();
    clock_ms = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_reset_timing();
    test_zero_timing();
    test_max_timing();
    test_random_timing();
    test_output_backpressure();
    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("button_edge_and_typematic_repeat test passed");
    else
      $display("button_edge_and_typematic_repeat test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("button_edge_and_typematic_repeat test failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/bte_pkg.sv
design/bte_in_reg.sv
design/bte_core.sv
design/button_edge_and_typematic_repeat.sv
design/bte_checker.sv
sim/testbench.sv
